[design/dktb_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dktb_pkg
// Shared types and constants of the distance key table builder.
// ----------------------------------------------------------------------------
package dktb_pkg;

  localparam int DefIndexCount = 32;
  localparam int DefMaskBits   = 32;
  localparam int DefCountBits  = 16;

  localparam int InDataW  = 32;
  localparam int OutDataW = 48;
  localparam int CfgDataW = 16;
  localparam int CfgIdxW  = 2;
  localparam int DivSteps = 18;

  typedef enum logic [1:0] {
    KIND_CLEAR = 2'd0,
    KIND_ADD   = 2'd1,
    KIND_READ  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    REG_FOLD_MODE = 2'd0,
    REG_DIST_MIN  = 2'd1,
    REG_DIST_INTV = 2'd2,
    REG_INTV_TOT  = 2'd3
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_WRITE,
    ST_RD1,
    ST_RD2
  } state_e;

  typedef struct packed {
    logic accept;
    logic div_start;
    logic div_step;
    logic add_write;
    logic clr_start;
    logic clr_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic [1:0] in_kind;
    logic       in_add_ok;
    logic       div_done;
    logic       clr_last;
    logic       out_free;
  } status_t;

endpackage
`default_nettype wire

[design/distance_key_table_builder.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// distance_key_table_builder
// Pair table of counts (saturating in fold mode, else set to one) and distance bin masks.
//
//  channel  | direction | content
//  s_axis   | in        | tuser: kind; tdata: index_a, index_b, distance, flags
//  m_axis   | out       | tdata: entry_count, entry_mask (read items only)
//  cfg      | in        | register writes, no read-back
//
// Add: 18-step restoring divider, then one table write.
// Read: states RD1 and RD2, then the output load, which waits out any output stall; ignored items are dropped.
// Clear and reset: sweep of all INDEX_COUNT*INDEX_COUNT entries (1024 by default),
// one entry per cycle, with s_axis not ready.
// ----------------------------------------------------------------------------
module distance_key_table_builder import dktb_pkg::*; #(
  parameter int INDEX_COUNT = DefIndexCount,
  parameter int MASK_BITS   = DefMaskBits,
  parameter int COUNT_BITS  = DefCountBits
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i,
  input  wire logic                s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  // [4:0] index_a, [9:5] index_b, [25:10] distance, [26] first_conformation,
  // [27] both_heavy, [31:28] zero
  input  wire logic [InDataW-1:0]  s_axis_tdata_i,
  // [1:0] kind
  input  wire logic [1:0]          s_axis_tuser_i,
  output logic                     m_axis_tvalid_o,
  input  wire logic                m_axis_tready_i,
  // [15:0] entry_count, [47:16] entry_mask
  output logic [OutDataW-1:0]      m_axis_tdata_o
);

  cmd_t    cmd;
  status_t status;

  dktb_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  dktb_datapath #(
    .INDEX_COUNT (INDEX_COUNT),
    .MASK_BITS   (MASK_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (s_axis_tdata_i),
    .in_kind_i   (s_axis_tuser_i),
    .out_data_o  (m_axis_tdata_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .cmd_i       (cmd),
    .status_o    (status)
  );

endmodule
`default_nettype wire

[design/dktb_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dktb_ctrl
// Sequencer: table sweep, bin division, read-modify-write and entry reads.
// ----------------------------------------------------------------------------
module dktb_ctrl import dktb_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    s_valid_i,
  output logic         s_ready_o,
  input  wire status_t status_i,
  output cmd_t         cmd_o
);

  state_e state_q, state_d;
  logic   take;

  assign s_ready_o = (state_q == ST_IDLE);
  assign take      = s_valid_i && s_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: if (status_i.clr_last) state_d = ST_IDLE;
      ST_IDLE: begin
        if (take) begin
          case (status_i.in_kind)
            KIND_CLEAR: state_d = ST_CLEAR;
            KIND_ADD:   if (status_i.in_add_ok) state_d = ST_DIV;
            KIND_READ:  state_d = ST_RD1;
            default:    state_d = ST_IDLE;
          endcase
        end
      end
      ST_DIV:   if (status_i.div_done) state_d = ST_WRITE;
      ST_WRITE: state_d = ST_IDLE;
      ST_RD1:   state_d = ST_RD2;
      ST_RD2:   if (status_i.out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    cmd_o.accept = take;
    case (state_q)
      ST_CLEAR: cmd_o.clr_step = 1'b1;
      ST_IDLE: begin
        cmd_o.div_start = take && (status_i.in_kind == KIND_ADD);
        cmd_o.clr_start = take && (status_i.in_kind == KIND_CLEAR);
      end
      ST_DIV:   cmd_o.div_step = 1'b1;
      ST_WRITE: cmd_o.add_write = 1'b1;
      ST_RD2:   cmd_o.out_load = status_i.out_free;
      default:  cmd_o = '0;
    endcase
  end

endmodule
`default_nettype wire

[design/dktb_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dktb_datapath
// Config registers, restoring bin divider, pair table memory, output register.
// ----------------------------------------------------------------------------
module dktb_datapath import dktb_pkg::*; #(
  parameter int INDEX_COUNT = DefIndexCount,
  parameter int MASK_BITS   = DefMaskBits,
  parameter int COUNT_BITS  = DefCountBits
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i,
  input  wire logic [InDataW-1:0]  in_data_i,
  input  wire logic [1:0]          in_kind_i,
  output logic [OutDataW-1:0]      out_data_o,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  input  wire cmd_t                cmd_i,
  output status_t                  status_o
);

  localparam int Depth = INDEX_COUNT * INDEX_COUNT;
  localparam int AddrW = $clog2(Depth);
  localparam int KeyW  = $clog2(MASK_BITS);
  localparam int WordW = COUNT_BITS + MASK_BITS;
  localparam int StepW = $clog2(DivSteps);

  // configuration
  logic        fold_q;
  logic [15:0] dmin_q, divl_q;
  logic [5:0]  itot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fold_q <= 1'b1;
      dmin_q <= 16'd0;
      divl_q <= 16'd256;
      itot_q <= 6'd32;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_index_i))
        REG_FOLD_MODE: fold_q <= cfg_wdata_i[0];
        REG_DIST_MIN:  dmin_q <= cfg_wdata_i;
        REG_DIST_INTV: divl_q <= cfg_wdata_i;
        REG_INTV_TOT:  itot_q <= cfg_wdata_i[5:0];
        default:       fold_q <= fold_q;
      endcase
    end
  end

  // input fields
  logic [4:0]  ia, ib, lo, hi;
  logic [15:0] dist_v;
  logic        first, heavy, in_valid;

  assign ia       = in_data_i[4:0];
  assign ib       = in_data_i[9:5];
  assign dist_v   = in_data_i[25:10];
  assign first    = in_data_i[26];
  assign heavy    = in_data_i[27];
  assign lo       = (ia < ib) ? ia : ib;
  assign hi       = (ia < ib) ? ib : ia;
  assign in_valid = (32'(hi) < INDEX_COUNT);

  // held item
  logic [AddrW-1:0] addr_q;
  logic             valid_q, first_q, neg_q;

  // divider: quotient of (2*mag + iv) / (2*iv)
  logic [15:0]        ive, mag;
  logic [17:0]        num_q, rem_q, rem_sh;
  logic [16:0]        den_q;
  logic [StepW-1:0]   step_q;
  logic [17:0]        rem_sub;
  logic               ge;

  assign ive     = (divl_q == 16'd0) ? 16'd1 : divl_q;
  assign mag     = (dist_v < dmin_q) ? (dmin_q - dist_v) : (dist_v - dmin_q);
  assign rem_sh  = {rem_q[16:0], num_q[17]};
  assign ge      = (rem_sh >= {1'b0, den_q});
  assign rem_sub = rem_sh - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else if (cmd_i.div_start) begin
      step_q <= '0;
    end else if (cmd_i.div_step) begin
      step_q <= step_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      addr_q  <= AddrW'(32'(lo) * INDEX_COUNT + 32'(hi));
      valid_q <= in_valid;
      first_q <= first;
      neg_q   <= (dist_v < dmin_q);
    end
    if (cmd_i.div_start) begin
      num_q <= {1'b0, mag, 1'b0} + {2'b00, ive};
      den_q <= {ive, 1'b0};
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      // num_q shifts out numerator bits and takes in quotient bits
      rem_q <= ge ? rem_sub : rem_sh;
      num_q <= {num_q[16:0], ge};
    end
  end

  assign status_o.div_done = (step_q == StepW'(DivSteps - 1));

  // bin key
  logic [6:0]      tot;
  logic [5:0]      kmax;
  logic [18:0]     qp1;
  logic [5:0]      key6;
  logic [KeyW-1:0] key;

  always_comb begin
    if (itot_q == 6'd0)                 tot = 7'd1;
    else if (32'(itot_q) > MASK_BITS)   tot = 7'(MASK_BITS);
    else                                tot = {1'b0, itot_q};
    kmax = 6'(tot - 7'd1);
    qp1  = {1'b0, num_q} + 19'd1;
    if (neg_q) begin
      key6 = (num_q == 18'd0) ? 6'd1 : 6'd0;
      if (key6 > kmax) key6 = kmax;
    end else begin
      key6 = (qp1 > 19'(kmax)) ? kmax : qp1[5:0];
    end
  end
  assign key = key6[KeyW-1:0];

  // table memory
  logic [WordW-1:0]      mem [Depth];
  logic [WordW-1:0]      rd_q, wr_word;
  logic [AddrW-1:0]      clr_q, wr_addr;
  logic [COUNT_BITS-1:0] cnt_old, cnt_new;
  logic [MASK_BITS-1:0]  msk_old, msk_new;
  logic                  wr_en;

  assign cnt_old = rd_q[WordW-1:MASK_BITS];
  assign msk_old = rd_q[MASK_BITS-1:0];

  always_comb begin
    cnt_new = cnt_old;
    if (first_q) begin
      if (!fold_q)              cnt_new = COUNT_BITS'(1);
      else if (cnt_old != '1)   cnt_new = cnt_old + 1'b1;
    end
    msk_new = msk_old | (MASK_BITS'(1) << key);
  end

  assign wr_en   = cmd_i.clr_step || cmd_i.add_write;
  assign wr_addr = cmd_i.clr_step ? clr_q : addr_q;
  assign wr_word = cmd_i.clr_step ? '0 : {cnt_new, msk_new};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clr_start) begin
      clr_q <= '0;
    end else if (cmd_i.clr_step) begin
      clr_q <= clr_q + 1'b1;
    end
  end

  assign status_o.clr_last = (clr_q == AddrW'(Depth - 1));

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_word;
    rd_q <= mem[addr_q];
  end

  // output register
  logic [COUNT_BITS+15:0] cnt_ext;
  logic [MASK_BITS+31:0]  msk_ext;
  logic                   out_valid_q;

  assign cnt_ext = {16'd0, cnt_old};
  assign msk_ext = {32'd0, msk_old};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_data_o <= valid_q ? {msk_ext[31:0], cnt_ext[15:0]} : '0;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign status_o.out_free  = !out_valid_q || out_ready_i;
  assign status_o.in_kind   = in_kind_i;
  assign status_o.in_add_ok = in_valid && heavy;

endmodule
`default_nettype wire
